// ===== src/ftas_pkg.sv =====
// shared types, codes and defaults of the flow table aging sweep
`default_nettype none
package ftas_pkg;

  localparam int unsigned NumBucketsDef = 1024;
  localparam int unsigned SlotsPerBucket = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned BucketFieldW = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned MinW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SlotDataW = 3 * WordW;

  localparam logic [WordW-1:0] TimeoutRst = '0;
  localparam logic [CountW-1:0] MaxExpRst = 6'd63;
  localparam logic [MinW-1:0] MinEntRst = '0;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_SWEEP = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_FINAL   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_MAX_EXP = 2'd1,
    CFG_MIN_ENT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_READ,
    ST_EVAL,
    ST_EMIT,
    ST_NEXT,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic load_req;
    logic reduce_step;
    logic sweep_init;
    logic wr_slot;
    logic rd_row;
    logic eval_row;
    logic emit_one;
    logic next_bkt;
    logic emit_final;
    logic clear_row;
  } cmd_t;

  typedef struct packed {
    logic red_done;
    logic is_sweep;
    logic disabled;
    logic mask_any;
    logic limit_hit;
    logic last_visit;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ftas_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module ftas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output logic      [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/ftas_ctrl.sv =====
// sequencer for writes, table clearing and aging sweeps
`default_nettype none
module ftas_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ftas_pkg::sts_t sts_i,
  output ftas_pkg::cmd_t      cmd_o
);

  ftas_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftas_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftas_pkg::ST_CLEAR: if (sts_i.clear_last) state_d = ftas_pkg::ST_IDLE;
      ftas_pkg::ST_IDLE: if (in_valid_i) state_d = ftas_pkg::ST_REDUCE;
      ftas_pkg::ST_REDUCE: begin
        if (sts_i.red_done) begin
          if (!sts_i.is_sweep) state_d = ftas_pkg::ST_WRITE;
          else if (sts_i.disabled) state_d = ftas_pkg::ST_FINAL;
          else state_d = ftas_pkg::ST_READ;
        end
      end
      ftas_pkg::ST_WRITE: if (sts_i.out_free) state_d = ftas_pkg::ST_IDLE;
      ftas_pkg::ST_READ: state_d = ftas_pkg::ST_EVAL;
      ftas_pkg::ST_EVAL: state_d = ftas_pkg::ST_EMIT;
      ftas_pkg::ST_EMIT: begin
        if (sts_i.limit_hit || !sts_i.mask_any) state_d = ftas_pkg::ST_NEXT;
      end
      ftas_pkg::ST_NEXT: begin
        if (sts_i.limit_hit || sts_i.last_visit) state_d = ftas_pkg::ST_FINAL;
        else state_d = ftas_pkg::ST_READ;
      end
      ftas_pkg::ST_FINAL: if (sts_i.out_free) state_d = ftas_pkg::ST_IDLE;
      default: state_d = ftas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftas_pkg::ST_CLEAR: cmd_o.clear_row = 1'b1;
      ftas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ftas_pkg::ST_REDUCE: begin
        cmd_o.reduce_step = !sts_i.red_done;
        cmd_o.sweep_init = sts_i.red_done;
      end
      ftas_pkg::ST_WRITE: cmd_o.wr_slot = sts_i.out_free;
      ftas_pkg::ST_READ: cmd_o.rd_row = 1'b1;
      ftas_pkg::ST_EVAL: cmd_o.eval_row = 1'b1;
      ftas_pkg::ST_EMIT: begin
        cmd_o.emit_one = !sts_i.limit_hit && sts_i.mask_any && sts_i.out_free;
      end
      ftas_pkg::ST_NEXT: cmd_o.next_bkt = 1'b1;
      ftas_pkg::ST_FINAL: cmd_o.emit_final = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ftas_datapath.sv =====
// table memories, request registers, expiry evaluation and output register
`default_nettype none
module ftas_datapath #(
  parameter int unsigned NumBuckets = ftas_pkg::NumBucketsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               req_type_i,
  input  wire logic [ftas_pkg::BucketFieldW-1:0]  bucket_i,
  input  wire logic [ftas_pkg::SlotW-1:0]         slot_i,
  input  wire logic [ftas_pkg::WordW-1:0]         key_hash_i,
  input  wire logic [ftas_pkg::WordW-1:0]         entry_index_i,
  input  wire logic [ftas_pkg::WordW-1:0]         entry_stamp_i,
  input  wire logic [ftas_pkg::WordW-1:0]         now_stamp_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [ftas_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ftas_pkg::WordW-1:0]         cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [1:0]                              kind_o,
  output logic [ftas_pkg::WordW-1:0]              expired_index_o,
  output logic [ftas_pkg::BucketFieldW-1:0]       next_bucket_o,
  output logic [ftas_pkg::CountW-1:0]             expired_count_o,
  output logic                                    last_o,
  input  wire ftas_pkg::cmd_t                     cmd_i,
  output ftas_pkg::sts_t                          sts_o
);

  localparam int unsigned BW = $clog2(NumBuckets);
  localparam int unsigned RW = (BW > ftas_pkg::BucketFieldW) ? BW : ftas_pkg::BucketFieldW;
  localparam int unsigned NS = ftas_pkg::SlotsPerBucket;
  localparam int unsigned WW = ftas_pkg::WordW;
  localparam int unsigned DW = ftas_pkg::SlotDataW;
  localparam logic [RW:0] NbWide = (RW+1)'(NumBuckets);
  localparam logic [BW-1:0] LastBkt = BW'(NumBuckets - 1);

  // config registers
  logic [WW-1:0] timeout_q;
  logic [ftas_pkg::CountW-1:0] max_q;
  logic [ftas_pkg::MinW-1:0] min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ftas_pkg::TimeoutRst;
      max_q <= ftas_pkg::MaxExpRst;
      min_q <= ftas_pkg::MinEntRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ftas_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        ftas_pkg::CFG_MAX_EXP: max_q <= cfg_data_i[ftas_pkg::CountW-1:0];
        ftas_pkg::CFG_MIN_ENT: min_q <= cfg_data_i[ftas_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  // request registers
  logic req_q;
  logic [ftas_pkg::BucketFieldW-1:0] bk_in_q;
  logic [RW-1:0] bk_q;
  logic [ftas_pkg::SlotW-1:0] slot_q;
  logic [WW-1:0] key_q, idx_q, stamp_q, now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      bk_in_q <= bucket_i;
      bk_q <= RW'(bucket_i);
      slot_q <= slot_i;
      key_q <= key_hash_i;
      idx_q <= entry_index_i;
      stamp_q <= entry_stamp_i;
      now_q <= now_stamp_i;
    end else if (cmd_i.reduce_step) begin
      bk_q <= bk_q - NbWide[RW-1:0];
    end
  end

  // sweep state
  logic [BW-1:0] cur_q, visits_q, clr_q;
  logic [ftas_pkg::CountW-1:0] count_q;
  logic [NS-1:0] exp_q, exp_d, low_oh;
  logic [DW-1:0] rdata [NS];
  logic [ftas_pkg::SlotW-1:0] low_idx;
  logic [ftas_pkg::MinW-1:0] used;
  logic skip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_row) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_init) begin
      cur_q <= bk_q[BW-1:0];
      visits_q <= '0;
      count_q <= '0;
    end else if (cmd_i.next_bkt) begin
      cur_q <= (cur_q == LastBkt) ? '0 : cur_q + 1'b1;
      visits_q <= visits_q + 1'b1;
    end else if (cmd_i.emit_one) begin
      count_q <= count_q + 1'b1;
    end
    if (cmd_i.eval_row) begin
      exp_q <= exp_d;
    end else if (cmd_i.emit_one) begin
      exp_q <= exp_q & ~low_oh;
    end
  end

  // expiry flags of the row just read
  always_comb begin
    used = '0;
    for (int s = 0; s < NS; s++) begin
      used = used + ftas_pkg::MinW'(rdata[s][DW-1 -: WW] != '0);
    end
    skip = (min_q > ftas_pkg::MinW'(1)) && (used < min_q);
    for (int s = 0; s < NS; s++) begin
      exp_d[s] = !skip && (rdata[s][DW-1 -: WW] != '0)
                 && ((now_q - rdata[s][WW-1:0]) > timeout_q);
    end
  end

  // lowest pending slot
  always_comb begin
    low_oh = exp_q & (~exp_q + 1'b1);
    low_idx = '0;
    for (int s = 0; s < NS; s++) begin
      if (low_oh[s]) low_idx = low_idx | ftas_pkg::SlotW'(s);
    end
  end

  // one memory per slot position, one row per bucket
  logic [BW-1:0] waddr;
  logic [DW-1:0] wdata;
  assign waddr = cmd_i.clear_row ? clr_q : (cmd_i.wr_slot ? bk_q[BW-1:0] : cur_q);
  assign wdata = cmd_i.wr_slot ? {key_q, idx_q, stamp_q} : '0;

  for (genvar s = 0; s < NS; s++) begin : g_slot
    logic we;
    assign we = cmd_i.clear_row
              || (cmd_i.wr_slot && (slot_q == ftas_pkg::SlotW'(s)))
              || (cmd_i.emit_one && low_oh[s]);
    ftas_ram #(.Width(DW), .Depth(NumBuckets)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (cmd_i.rd_row),
      .raddr_i(cur_q),
      .rdata_o(rdata[s])
    );
  end

  // output register
  logic out_valid_q;
  logic out_free;
  logic disabled;
  logic [RW-1:0] cur_ext;
  assign out_free = !out_valid_q || out_ready_i;
  assign disabled = (timeout_q == '0) || (max_q == '0);
  assign cur_ext = RW'(cur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr_slot || cmd_i.emit_one || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_slot) begin
      kind_o <= ftas_pkg::KIND_WRITE;
      expired_index_o <= '0;
      next_bucket_o <= '0;
      expired_count_o <= '0;
      last_o <= 1'b1;
    end else if (cmd_i.emit_one) begin
      kind_o <= ftas_pkg::KIND_EXPIRED;
      expired_index_o <= rdata[low_idx][2*WW-1:WW];
      next_bucket_o <= '0;
      expired_count_o <= '0;
      last_o <= 1'b0;
    end else if (cmd_i.emit_final) begin
      kind_o <= ftas_pkg::KIND_FINAL;
      expired_index_o <= '0;
      next_bucket_o <= disabled ? bk_in_q : cur_ext[ftas_pkg::BucketFieldW-1:0];
      expired_count_o <= count_q;
      last_o <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.red_done = {1'b0, bk_q} < NbWide;
    sts_o.is_sweep = (req_q == ftas_pkg::REQ_SWEEP);
    sts_o.disabled = disabled;
    sts_o.mask_any = exp_q != '0;
    sts_o.limit_hit = count_q >= max_q;
    sts_o.last_visit = visits_q == LastBkt;
    sts_o.clear_last = clr_q == LastBkt;
    sts_o.out_free = out_free;
  end

  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_one |-> (exp_q != '0) && (count_q < max_q))
    else $error("eviction without pending slot or past limit");

  a_emit_clears_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_one |=> $countones(exp_q) == $past($countones(exp_q)) - 1)
    else $error("eviction did not retire exactly one slot");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_slot || cmd_i.emit_one || cmd_i.emit_final) |-> out_free)
    else $error("output register overwritten");

  a_start_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_init |-> ({1'b0, bk_q} < NbWide))
    else $error("sweep starts at unreduced bucket");

endmodule
`default_nettype wire

// ===== src/flow_table_aging_sweep_top.sv =====
// top level of the flow table aging sweep
// sequence: a write result is loaded after acceptance, bucket reduction (one subtract of
//   NumBuckets per cycle while the bucket is out of range) and the write state; a sweep
//   has a start step, then per visited bucket a row read, evaluate, slot scan and advance,
//   one scan step more per eviction, and a final result step
// concurrency: one transaction at a time
// reset: a clearing pass zeroes every row, no input is taken then
`default_nettype none
module flow_table_aging_sweep_top #(
  parameter int unsigned NumBuckets = ftas_pkg::NumBucketsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               req_type_i,
  input  wire logic [ftas_pkg::BucketFieldW-1:0]  bucket_i,
  input  wire logic [ftas_pkg::SlotW-1:0]         slot_i,
  input  wire logic [ftas_pkg::WordW-1:0]         key_hash_i,
  input  wire logic [ftas_pkg::WordW-1:0]         entry_index_i,
  input  wire logic [ftas_pkg::WordW-1:0]         entry_stamp_i,
  input  wire logic [ftas_pkg::WordW-1:0]         now_stamp_i,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ftas_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ftas_pkg::WordW-1:0]         cfg_data_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [1:0]                              kind_o,
  output logic [ftas_pkg::WordW-1:0]              expired_index_o,
  output logic [ftas_pkg::BucketFieldW-1:0]       next_bucket_o,
  output logic [ftas_pkg::CountW-1:0]             expired_count_o,
  output logic                                    last_o
);

  // control and status between sequencer and datapath
  ftas_pkg::cmd_t cmd;
  ftas_pkg::sts_t sts;

  // config registers accept a transaction every cycle
  assign cfg_ready_o = 1'b1;

  ftas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // holds the table rows, one memory per slot position
  ftas_datapath #(.NumBuckets(NumBuckets)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .bucket_i       (bucket_i),
    .slot_i         (slot_i),
    .key_hash_i     (key_hash_i),
    .entry_index_i  (entry_index_i),
    .entry_stamp_i  (entry_stamp_i),
    .now_stamp_i    (now_stamp_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .expired_index_o(expired_index_o),
    .next_bucket_o  (next_bucket_o),
    .expired_count_o(expired_count_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the flow table aging sweep: predicts every result and checks it in order
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Buckets = 1024;
  localparam int unsigned TableSlots = Buckets * ftas_pkg::SlotsPerBucket;
  // a full sweep visits every bucket, plenty of headroom for stalls
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SettleCycles = 40;

  typedef struct {
    ftas_pkg::req_e                    req;
    logic [ftas_pkg::BucketFieldW-1:0] bucket;
    logic [ftas_pkg::SlotW-1:0]        slot;
    logic [ftas_pkg::WordW-1:0]        key_hash;
    logic [ftas_pkg::WordW-1:0]        entry_index;
    logic [ftas_pkg::WordW-1:0]        entry_stamp;
    logic [ftas_pkg::WordW-1:0]        now_stamp;
  } flow_req_t;

  typedef struct {
    ftas_pkg::kind_e                   kind;
    logic [ftas_pkg::WordW-1:0]        expired_index;
    logic [ftas_pkg::BucketFieldW-1:0] next_bucket;
    logic [ftas_pkg::CountW-1:0]       expired_count;
    logic                              last;
  } flow_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic                              req_type_i = 1'b0;
  logic [ftas_pkg::BucketFieldW-1:0] bucket_i = '0;
  logic [ftas_pkg::SlotW-1:0]        slot_i = '0;
  logic [ftas_pkg::WordW-1:0]        key_hash_i = '0;
  logic [ftas_pkg::WordW-1:0]        entry_index_i = '0;
  logic [ftas_pkg::WordW-1:0]        entry_stamp_i = '0;
  logic [ftas_pkg::WordW-1:0]        now_stamp_i = '0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [ftas_pkg::CfgIdxW-1:0]      cfg_index_i = '0;
  logic [ftas_pkg::WordW-1:0]        cfg_data_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [1:0]                        kind_o;
  logic [ftas_pkg::WordW-1:0]        expired_index_o;
  logic [ftas_pkg::BucketFieldW-1:0] next_bucket_o;
  logic [ftas_pkg::CountW-1:0]       expired_count_o;
  logic                              last_o;

  flow_table_aging_sweep_top #(.NumBuckets(Buckets)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the table and of the registers
  logic [ftas_pkg::WordW-1:0]  shadow_hash [TableSlots];
  logic [ftas_pkg::WordW-1:0]  shadow_index [TableSlots];
  logic [ftas_pkg::WordW-1:0]  shadow_stamp [TableSlots];
  logic [ftas_pkg::WordW-1:0]  age_limit = ftas_pkg::TimeoutRst;
  logic [ftas_pkg::CountW-1:0] evict_limit = ftas_pkg::MaxExpRst;
  logic [ftas_pkg::MinW-1:0]   occupancy_floor = ftas_pkg::MinEntRst;

  flow_req_t pending_reqs[$];
  flow_rsp_t expected_rsps[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;

  function automatic void push_rsp(ftas_pkg::kind_e k, logic [ftas_pkg::WordW-1:0] idx,
                                   logic [ftas_pkg::BucketFieldW-1:0] nb,
                                   logic [ftas_pkg::CountW-1:0] cnt, logic lst);
    flow_rsp_t r;
    r.kind = k;
    r.expired_index = idx;
    r.next_bucket = nb;
    r.expired_count = cnt;
    r.last = lst;
    expected_rsps.push_back(r);
  endfunction

  // applies one accepted transaction to the shadow table and queues its results
  function automatic void age_table(flow_req_t q);
    int unsigned cur, base, used, p;
    logic [ftas_pkg::CountW-1:0] count;
    logic [ftas_pkg::WordW-1:0] age;
    cur = q.bucket % Buckets;
    count = '0;
    if (q.req == ftas_pkg::REQ_WRITE) begin
      p = cur * ftas_pkg::SlotsPerBucket + q.slot;
      shadow_hash[p] = q.key_hash;
      shadow_index[p] = q.entry_index;
      shadow_stamp[p] = q.entry_stamp;
      push_rsp(ftas_pkg::KIND_WRITE, '0, '0, '0, 1'b1);
      return;
    end
    // disabled sweep answers at once with the start bucket
    if (evict_limit == 0 || age_limit == 0) begin
      push_rsp(ftas_pkg::KIND_FINAL, '0, q.bucket, '0, 1'b1);
      return;
    end
    for (int i = 0; i < Buckets; i++) begin
      base = cur * ftas_pkg::SlotsPerBucket;
      used = 0;
      for (int s = 0; s < ftas_pkg::SlotsPerBucket; s++)
        if (shadow_hash[base + s] != 0) used++;
      if (!(occupancy_floor > 1 && used < occupancy_floor)) begin
        for (int s = 0; s < ftas_pkg::SlotsPerBucket && count < evict_limit; s++) begin
          p = base + s;
          age = q.now_stamp - shadow_stamp[p];
          if (shadow_hash[p] != 0 && age > age_limit) begin
            push_rsp(ftas_pkg::KIND_EXPIRED, shadow_index[p], '0, '0, 1'b0);
            shadow_hash[p] = '0;
            shadow_index[p] = '0;
            shadow_stamp[p] = '0;
            count++;
          end
        end
      end
      cur = (cur + 1) % Buckets;
      if (count >= evict_limit) break;
    end
    push_rsp(ftas_pkg::KIND_FINAL, '0, cur[ftas_pkg::BucketFieldW-1:0], count, 1'b1);
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_write(logic [ftas_pkg::BucketFieldW-1:0] b,
                                      logic [ftas_pkg::SlotW-1:0] s,
                                      logic [ftas_pkg::WordW-1:0] h,
                                      logic [ftas_pkg::WordW-1:0] idx,
                                      logic [ftas_pkg::WordW-1:0] st);
    flow_req_t q;
    q.req = ftas_pkg::REQ_WRITE;
    q.bucket = b;
    q.slot = s;
    q.key_hash = h;
    q.entry_index = idx;
    q.entry_stamp = st;
    q.now_stamp = $urandom;
    pending_reqs.push_back(q);
  endfunction

  function automatic void queue_sweep(logic [ftas_pkg::BucketFieldW-1:0] b,
                                      logic [ftas_pkg::WordW-1:0] now);
    flow_req_t q;
    q.req = ftas_pkg::REQ_SWEEP;
    q.bucket = b;
    q.slot = ftas_pkg::SlotW'($urandom);
    q.key_hash = $urandom;
    q.entry_index = $urandom;
    q.entry_stamp = $urandom;
    q.now_stamp = now;
    pending_reqs.push_back(q);
  endfunction

  task automatic report_mismatch(string what, logic [ftas_pkg::WordW-1:0] got,
                                 logic [ftas_pkg::WordW-1:0] want);
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // request driver
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    flow_req_t q;
    bit taken;
    taken = in_valid_i && in_ready_o;
    if (taken) begin
      age_table('{req: ftas_pkg::req_e'(req_type_i), bucket: bucket_i, slot: slot_i,
                  key_hash: key_hash_i, entry_index: entry_index_i,
                  entry_stamp: entry_stamp_i, now_stamp: now_stamp_i});
      in_gap = pick_gap();
    end
    if (!in_valid_i || taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        req_type_i <= q.req;
        bucket_i <= q.bucket;
        slot_i <= q.slot;
        key_hash_i <= q.key_hash;
        entry_index_i <= q.entry_index;
        entry_stamp_i <= q.entry_stamp;
        now_stamp_i <= q.now_stamp;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor with random back pressure
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    flow_rsp_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected transaction kind", kind_o, '0);
      end else begin
        e = expected_rsps.pop_front();
        if (kind_o != e.kind) report_mismatch("kind", kind_o, e.kind);
        if (expired_index_o != e.expired_index)
          report_mismatch("expired_index", expired_index_o, e.expired_index);
        if (next_bucket_o != e.next_bucket)
          report_mismatch("next_bucket", next_bucket_o, e.next_bucket);
        if (expired_count_o != e.expired_count)
          report_mismatch("expired_count", expired_count_o, e.expired_count);
        if (last_o != e.last) report_mismatch("last", last_o, e.last);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // one register write, shadow updated when the transaction completes
  task automatic write_reg(ftas_pkg::cfg_idx_e idx, logic [ftas_pkg::WordW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ftas_pkg::CFG_TIMEOUT: age_limit = data;
      ftas_pkg::CFG_MAX_EXP: evict_limit = data[ftas_pkg::CountW-1:0];
      ftas_pkg::CFG_MIN_ENT: occupancy_floor = data[ftas_pkg::MinW-1:0];
      default: ;
    endcase
  endtask

  // sender pauses here until every queued transaction has been answered
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_rsps.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [ftas_pkg::WordW-1:0] pick_age(logic [ftas_pkg::WordW-1:0] lim);
    case ($urandom_range(0, 5))
      0: return lim;
      1: return lim + 1;
      2: return lim - 1;
      3: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // well-formed traffic: writes into a cluster of buckets, mixed with sweeps that start near it
  task automatic random_phase(int unsigned n);
    logic [ftas_pkg::BucketFieldW-1:0] hot, b;
    logic [ftas_pkg::WordW-1:0] now, h;
    hot = ftas_pkg::BucketFieldW'($urandom);
    now = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 22) begin
        b = ($urandom_range(0, 3) == 0) ? ftas_pkg::BucketFieldW'($urandom)
          : ftas_pkg::BucketFieldW'(hot + $urandom_range(0, 5));
        queue_sweep(b, now + $urandom_range(0, 3));
      end else begin
        b = ($urandom_range(0, 9) == 0) ? ftas_pkg::BucketFieldW'($urandom)
          : ftas_pkg::BucketFieldW'(hot + $urandom_range(0, 7));
        h = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
        queue_write(b, ftas_pkg::SlotW'($urandom), h, $urandom, now - pick_age(age_limit));
      end
    end
  endtask

  initial begin
    logic [ftas_pkg::WordW-1:0] tmo [6];
    logic [ftas_pkg::WordW-1:0] lim [5];
    logic [ftas_pkg::WordW-1:0] flr [5];
    tmo = '{32'd1, 32'd1000, 32'hffff_ffff, 32'h8000_0000, 32'd0, 32'd37};
    lim = '{32'd1, 32'd63, 32'd5, 32'd0, 32'd2};
    flr = '{32'd0, 32'd1, 32'd2, 32'd16, 32'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: timeout zero, so a sweep changes nothing
    queue_write(10'd0, 4'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
    queue_write(10'd1023, 4'd15, 32'h8000_0000, 32'h1234_5678, 32'hffff_ffff);
    queue_sweep(10'd1023, 32'hffff_ffff);
    drain();

    // timeout 100: boundary ages, wrapped stamps and empty hashes
    write_reg(ftas_pkg::CFG_TIMEOUT, 32'd100);
    write_reg(ftas_pkg::CFG_MAX_EXP, 32'd63);
    write_reg(ftas_pkg::CFG_MIN_ENT, 32'd0);
    queue_write(10'd0, 4'd1, 32'd5, 32'd11, 32'd0);      // age 100, stays
    queue_write(10'd0, 4'd2, 32'd6, 32'd12, 32'hffff_fff0); // wraps, age 116
    queue_write(10'd0, 4'd3, 32'd0, 32'd13, 32'd0);      // empty slot
    queue_write(10'd2, 4'd0, 32'd7, 32'd14, 32'd200);    // stamp ahead of now
    queue_sweep(10'd1023, 32'd100);
    queue_sweep(10'd0, 32'd101);
    drain();

    // evict limit of one stops the walk early
    write_reg(ftas_pkg::CFG_MAX_EXP, 32'd1);
    queue_write(10'd5, 4'd0, 32'd1, 32'd21, 32'd0);
    queue_write(10'd5, 4'd9, 32'd1, 32'd22, 32'd0);
    queue_sweep(10'd4, 32'd5000);
    queue_sweep(10'd4, 32'd5000);
    drain();

    // occupancy floors: sparse buckets skipped, full row needed at sixteen
    write_reg(ftas_pkg::CFG_MAX_EXP, 32'd63);
    write_reg(ftas_pkg::CFG_MIN_ENT, 32'd2);
    queue_write(10'd8, 4'd0, 32'd3, 32'd31, 32'd0);
    queue_sweep(10'd8, 32'd9000);
    drain();
    write_reg(ftas_pkg::CFG_MIN_ENT, 32'd16);
    queue_sweep(10'd8, 32'd9000);
    drain();
    write_reg(ftas_pkg::CFG_TIMEOUT, 32'hffff_ffff);
    queue_sweep(10'd8, 32'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ftas_pkg::CFG_TIMEOUT, (ph == 7) ? $urandom : tmo[ph % 6]);
      write_reg(ftas_pkg::CFG_MAX_EXP, (ph == 6) ? $urandom_range(1, 63) : lim[ph % 5]);
      write_reg(ftas_pkg::CFG_MIN_ENT, (ph == 5) ? $urandom_range(0, 16) : flr[ph % 5]);
      no_idle = (ph % 3 == 1);
      random_phase(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
